/* rtl/rc_link_frame_receiver_macros.svh */
// Assertion macros for the RC link frame receiver.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef RC_LINK_FRAME_RECEIVER_MACROS_SVH
`define RC_LINK_FRAME_RECEIVER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RCLFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RCLFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rclfr_pkg.sv */
// Shared constants, result kinds and config types for the RC link frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rclfr_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int MIN_FRAME_BYTES = 4;
    localparam int RC_FRAME_TYPE   = 22;
    localparam int LINK_FRAME_TYPE = 20;
    localparam int NUM_CHANNELS    = 12;
    localparam int LINK_STAT_BYTES = 10;
    localparam int RAW_MASK        = 'h07FF;

    localparam int ADDR_W  = $clog2(MAX_FRAME_BYTES);
    localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);

    // config register indexes
    localparam logic [2:0] CFG_SYNC_VALUE    = 3'd0;
    localparam logic [2:0] CFG_CRC_POLY      = 3'd1;
    localparam logic [2:0] CFG_BYTE_TIMEOUT  = 3'd2;
    localparam logic [2:0] CFG_FAILSAFE      = 3'd3;
    localparam logic [2:0] CFG_RAW_MIN       = 3'd4;
    localparam logic [2:0] CFG_SCALE_RATIO   = 3'd5;
    localparam logic [2:0] CFG_OUT_MIN       = 3'd6;
    localparam logic [2:0] CFG_OUT_MAX       = 3'd7;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        KIND_CHANNEL   = 3'd0,
        KIND_LINK_STAT = 3'd1,
        KIND_SYNC_ERR  = 3'd2,
        KIND_CRC_ERR   = 3'd3,
        KIND_TIMEOUT   = 3'd4,
        KIND_FAILSAFE  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [10:0] raw_min;
        logic [16:0] ratio_q16;
        logic [11:0] out_min;
        logic [11:0] out_max;
    } scale_cfg_t;

endpackage
`default_nettype wire

/* rtl/rclfr_scaler.sv */
// Channel scaler: Q16 multiply, rounding and clamp over two register stages.
// Depends on rclfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rclfr_scaler (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [10:0]          raw,
    input  wire rclfr_pkg::scale_cfg_t cfg,
    output logic                      done,
    output logic [11:0]               result
);
    import rclfr_pkg::*;

    logic signed [29:0] prod_reg;
    logic               stage_reg;
    logic               done_reg;
    logic [11:0]        result_reg;

    logic signed [11:0] diff;
    logic signed [29:0] prod_next;
    logic signed [31:0] sum;
    logic signed [15:0] quot;
    logic [11:0]        result_next;

    always_comb
    begin
        diff      = $signed({1'b0, raw}) - $signed({1'b0, cfg.raw_min});
        prod_next = 30'($signed({1'b0, cfg.ratio_q16}) * diff);
        // out_min * 65536 + 0.5 in Q16
        sum  = $signed({4'b0, cfg.out_min, 16'h8000}) + 32'(prod_reg);
        quot = sum[31:16];
        result_next = 12'(quot);
        if (quot < $signed({4'b0, cfg.out_min}))
            result_next = cfg.out_min;
        // max wins when min > max
        if (quot > $signed({4'b0, cfg.out_max}) || result_next > cfg.out_max)
            result_next = cfg.out_max;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= prod_next;
        if (stage_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* rtl/rc_link_frame_receiver.sv */
// RC link frame receiver: byte/tick sequencer, frame buffer, CRC8 and emitters.
// Depends on rclfr_pkg, rclfr_scaler and rc_link_frame_receiver_macros.svh.
//
// Takes one word per cycle while idle; a byte that does not end a frame and
// a tick that causes no result leave it idle. A tick with results stays in
// S_TICK until it has emitted each of them. A completed frame is walked
// through the single read port of the frame buffer: CRC over len-1 bytes plus
// the check byte, then for each RC channel three buffer reads, a wait on the
// scaler and one emit, or for a link frame one read and emit per byte.
// in_stall is high while a frame or tick is being worked off. cfg_ready is
// always high; write config only while idle.
`timescale 1ns / 1ps
`default_nettype none
module rc_link_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [3:0]       item_index,
    output logic [15:0]      value,
    output logic             failsafe_active,
    output logic             last_of_run,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import rclfr_pkg::*;
    `include "rc_link_frame_receiver_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_CRC, S_CMP, S_ERR, S_CH, S_SCL, S_CHOUT, S_LNK
    } state_t;

    // config
    logic [7:0]  sync_value_reg, crc_poly_reg;
    logic [15:0] byte_timeout_reg, failsafe_ticks_reg;
    scale_cfg_t  scale_cfg_reg;

    // frame buffer
    logic [7:0]        mem [MAX_FRAME_BYTES];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] rd_pos_reg;
    logic              mem_we;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] chk_count_reg, chk_count_next;
    logic [7:0]         byte0_reg, byte0_next, len_reg, len_next, type_reg, type_next;
    logic [15:0]        idle_reg, idle_next, tsv_reg, tsv_next;
    logic               fs_reg, fs_next;
    logic [15:0]        sync_cnt_reg, sync_cnt_next, crc_cnt_reg, crc_cnt_next;
    logic [15:0]        to_cnt_reg, to_cnt_next;
    logic               to_pend_reg, to_pend_next, fs_pend_reg, fs_pend_next;
    logic               nf_reg, nf_next;
    logic               sync_bad_reg, sync_bad_next, crc_bad_reg, crc_bad_next;
    logic [7:0]         crc_reg, crc_next;
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic               wait_reg, wait_next;
    logic [3:0]         idx_reg, idx_next;
    logic [1:0]         k_reg, k_next;
    logic [15:0]        w_reg, w_next;

    logic        out_valid_reg, out_valid_next, last_reg, last_next, fs_out_reg, fs_out_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  index_reg, index_next;
    logic [15:0] value_reg, value_next;

    logic        accept, out_free, scl_start, scl_done;
    logic [11:0] scl_result;
    logic [10:0] scl_raw;
    logic [7:0]  rbyte;
    logic [6:0]  bitpos;
    logic [15:0] idle_inc, tsv_inc;
    logic        nf, to_hit, trig;

    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b,
                                            input logic [7:0] poly);
        logic [7:0] x;
        x = c ^ b;
        for (int i = 0; i < 8; i++)
            x = x[7] ? ((x << 1) ^ poly) : (x << 1);
        return x;
    endfunction

    function automatic logic [6:0] ch_bitpos(input logic [3:0] ch);
        return ({3'b0, ch} << 3) + ({3'b0, ch} << 1) + {3'b0, ch};
    endfunction

    function automatic logic [ADDR_W-1:0] ch_base(input logic [3:0] ch);
        logic [6:0] p;
        p = ch_bitpos(ch);
        return ADDR_W'(3) + ADDR_W'(p[6:3]);
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    // positions past the frame end read as zero
    assign rbyte     = ({1'b0, rd_pos_reg} < chk_count_reg) ? rdata_reg : 8'd0;
    assign bitpos    = ch_bitpos(idx_reg);
    assign scl_raw   = 11'(({rbyte, w_reg} >> bitpos[2:0]) & 24'(RAW_MASK));
    assign idle_inc  = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign tsv_inc   = (tsv_reg != 16'hFFFF) ? tsv_reg + 16'd1 : tsv_reg;
    assign to_hit    = (idle_inc > byte_timeout_reg) && (byte_count_reg != '0);
    assign nf        = (tsv_inc > failsafe_ticks_reg);

    rclfr_scaler u_scaler (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scl_start),
        .raw    (scl_raw),
        .cfg    (scale_cfg_reg),
        .done   (scl_done),
        .result (scl_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        chk_count_next  = chk_count_reg;
        byte0_next      = byte0_reg;
        len_next        = len_reg;
        type_next       = type_reg;
        idle_next       = idle_reg;
        tsv_next        = tsv_reg;
        fs_next         = fs_reg;
        sync_cnt_next   = sync_cnt_reg;
        crc_cnt_next    = crc_cnt_reg;
        to_cnt_next     = to_cnt_reg;
        to_pend_next    = to_pend_reg;
        fs_pend_next    = fs_pend_reg;
        nf_next         = nf_reg;
        sync_bad_next   = sync_bad_reg;
        crc_bad_next    = crc_bad_reg;
        crc_next        = crc_reg;
        rd_addr_next    = rd_addr_reg;
        wait_next       = 1'b0;
        idx_next        = idx_reg;
        k_next          = k_reg;
        w_next          = w_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        index_next      = index_reg;
        value_next      = value_reg;
        fs_out_next     = fs_out_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        scl_start       = 1'b0;
        trig            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && opcode == OP_BYTE)
                begin
                    idle_next = '0;
                    if (byte_count_reg < COUNT_W'(MAX_FRAME_BYTES - 1))
                    begin
                        mem_we          = 1'b1;
                        byte_count_next = byte_count_reg + 1'b1;
                        if (byte_count_reg == COUNT_W'(0)) byte0_next = rx_byte;
                        if (byte_count_reg == COUNT_W'(1)) len_next   = rx_byte;
                        if (byte_count_reg == COUNT_W'(2)) type_next  = rx_byte;
                    end
                    trig = (byte_count_next > COUNT_W'(MIN_FRAME_BYTES)) &&
                           ({2'b0, byte_count_next} == {1'b0, len_reg} + 9'd2);
                    if (trig)
                    begin
                        chk_count_next  = byte_count_next;
                        byte_count_next = '0;
                        crc_next        = '0;
                        rd_addr_next    = ADDR_W'(2);
                        wait_next       = 1'b1;
                        state_next      = S_CRC;
                    end
                end
                else if (accept)
                begin
                    idle_next    = idle_inc;
                    tsv_next     = tsv_inc;
                    to_pend_next = to_hit;
                    fs_pend_next = (nf != fs_reg);
                    nf_next      = nf;
                    if (to_hit)
                        byte_count_next = '0;
                    if (to_hit || nf != fs_reg)
                        state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    index_next     = '0;
                    if (to_pend_reg)
                    begin
                        to_cnt_next  = to_cnt_reg + 16'd1;
                        kind_next    = KIND_TIMEOUT;
                        value_next   = to_cnt_reg + 16'd1;
                        fs_out_next  = fs_reg;
                        last_next    = !fs_pend_reg;
                        to_pend_next = 1'b0;
                        if (!fs_pend_reg) state_next = S_IDLE;
                    end
                    else
                    begin
                        fs_next      = nf_reg;
                        kind_next    = KIND_FAILSAFE;
                        value_next   = {15'd0, nf_reg};
                        fs_out_next  = nf_reg;
                        last_next    = 1'b1;
                        fs_pend_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_CRC:
            begin
                if (wait_reg)
                    wait_next = 1'b0;
                else
                begin
                    crc_next     = crc_step(crc_reg, rbyte, crc_poly_reg);
                    rd_addr_next = rd_addr_reg + 1'b1;
                    wait_next    = 1'b1;
                    if ({2'b0, rd_addr_reg} == len_reg)
                        state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (wait_reg)
                    wait_next = 1'b0;
                else
                begin
                    sync_bad_next = (byte0_reg != sync_value_reg);
                    crc_bad_next  = (crc_reg != rbyte);
                    if (byte0_reg == sync_value_reg && crc_reg == rbyte &&
                        type_reg == 8'(RC_FRAME_TYPE))
                        tsv_next = '0;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                if (sync_bad_reg || crc_bad_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        index_next     = '0;
                        fs_out_next    = fs_reg;
                        if (sync_bad_reg)
                        begin
                            sync_cnt_next = sync_cnt_reg + 16'd1;
                            kind_next     = KIND_SYNC_ERR;
                            value_next    = sync_cnt_reg + 16'd1;
                            last_next     = !crc_bad_reg;
                            sync_bad_next = 1'b0;
                            if (!crc_bad_reg) state_next = S_IDLE;
                        end
                        else
                        begin
                            crc_cnt_next = crc_cnt_reg + 16'd1;
                            kind_next    = KIND_CRC_ERR;
                            value_next   = crc_cnt_reg + 16'd1;
                            last_next    = 1'b1;
                            crc_bad_next = 1'b0;
                            state_next   = S_IDLE;
                        end
                    end
                end
                else if (type_reg == 8'(RC_FRAME_TYPE))
                begin
                    idx_next     = '0;
                    k_next       = '0;
                    rd_addr_next = ch_base(4'd0);
                    wait_next    = 1'b1;
                    state_next   = S_CH;
                end
                else if (type_reg == 8'(LINK_FRAME_TYPE))
                begin
                    idx_next     = '0;
                    rd_addr_next = ADDR_W'(3);
                    wait_next    = 1'b1;
                    state_next   = S_LNK;
                end
                else
                    state_next = S_IDLE;
            end
            S_CH:
            begin
                if (wait_reg)
                    wait_next = 1'b0;
                else if (k_reg == 2'd2)
                begin
                    scl_start  = 1'b1;
                    state_next = S_SCL;
                end
                else
                begin
                    if (k_reg == 2'd0) w_next[7:0]  = rbyte;
                    else               w_next[15:8] = rbyte;
                    k_next       = k_reg + 1'b1;
                    rd_addr_next = rd_addr_reg + 1'b1;
                    wait_next    = 1'b1;
                end
            end
            S_SCL:
            begin
                if (scl_done)
                    state_next = S_CHOUT;
            end
            S_CHOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_CHANNEL;
                    index_next     = idx_reg;
                    value_next     = {4'd0, scl_result};
                    fs_out_next    = fs_reg;
                    last_next      = (idx_reg == 4'(NUM_CHANNELS - 1));
                    if (idx_reg == 4'(NUM_CHANNELS - 1))
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        k_next       = '0;
                        rd_addr_next = ch_base(idx_reg + 1'b1);
                        wait_next    = 1'b1;
                        state_next   = S_CH;
                    end
                end
            end
            S_LNK:
            begin
                if (wait_reg)
                    wait_next = 1'b0;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_LINK_STAT;
                    index_next     = idx_reg;
                    value_next     = {8'd0, rbyte};
                    fs_out_next    = fs_reg;
                    last_next      = (idx_reg == 4'(LINK_STAT_BYTES - 1));
                    if (idx_reg == 4'(LINK_STAT_BYTES - 1))
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        rd_addr_next = rd_addr_reg + 1'b1;
                        wait_next    = 1'b1;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            byte_count_reg     <= '0;
            chk_count_reg      <= '0;
            idle_reg           <= '0;
            tsv_reg            <= 16'hFFFF;
            fs_reg             <= 1'b1;
            sync_cnt_reg       <= '0;
            crc_cnt_reg        <= '0;
            to_cnt_reg         <= '0;
            to_pend_reg        <= 1'b0;
            fs_pend_reg        <= 1'b0;
            sync_bad_reg       <= 1'b0;
            crc_bad_reg        <= 1'b0;
            wait_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
            sync_value_reg     <= 8'd200;
            crc_poly_reg       <= 8'd213;
            byte_timeout_reg   <= 16'd5;
            failsafe_ticks_reg <= 16'd1000;
            scale_cfg_reg      <= '{raw_min: 11'd172, ratio_q16: 17'd40950,
                                    out_min: 12'd988, out_max: 12'd2012};
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            chk_count_reg  <= chk_count_next;
            idle_reg       <= idle_next;
            tsv_reg        <= tsv_next;
            fs_reg         <= fs_next;
            sync_cnt_reg   <= sync_cnt_next;
            crc_cnt_reg    <= crc_cnt_next;
            to_cnt_reg     <= to_cnt_next;
            to_pend_reg    <= to_pend_next;
            fs_pend_reg    <= fs_pend_next;
            sync_bad_reg   <= sync_bad_next;
            crc_bad_reg    <= crc_bad_next;
            wait_reg       <= wait_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC_VALUE:   sync_value_reg          <= cfg_data[7:0];
                    CFG_CRC_POLY:     crc_poly_reg            <= cfg_data[7:0];
                    CFG_BYTE_TIMEOUT: byte_timeout_reg        <= cfg_data[15:0];
                    CFG_FAILSAFE:     failsafe_ticks_reg      <= cfg_data[15:0];
                    CFG_RAW_MIN:      scale_cfg_reg.raw_min   <= cfg_data[10:0];
                    CFG_SCALE_RATIO:  scale_cfg_reg.ratio_q16 <= cfg_data[16:0];
                    CFG_OUT_MIN:      scale_cfg_reg.out_min   <= cfg_data[11:0];
                    CFG_OUT_MAX:      scale_cfg_reg.out_max   <= cfg_data[11:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        byte0_reg   <= byte0_next;
        len_reg     <= len_next;
        type_reg    <= type_next;
        nf_reg      <= nf_next;
        crc_reg     <= crc_next;
        rd_addr_reg <= rd_addr_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        w_reg       <= w_next;
        kind_reg    <= kind_next;
        index_reg   <= index_next;
        value_reg   <= value_next;
        fs_out_reg  <= fs_out_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[byte_count_reg[ADDR_W-1:0]] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg  <= mem[rd_addr_reg];
        rd_pos_reg <= rd_addr_reg;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign item_index      = index_reg;
    assign value           = value_reg;
    assign failsafe_active = fs_out_reg;
    assign last_of_run     = last_reg;

    `RCLFR_ASSERT_NOW(a_scl_done_state, scl_done, state_reg == S_SCL,
        "scaler finished outside the scale wait")
    `RCLFR_ASSERT_NOW(a_last_channel, out_valid && kind == KIND_CHANNEL && last_of_run,
        item_index == 4'(NUM_CHANNELS - 1), "channel run ended early")
    `RCLFR_ASSERT_NOW(a_count_bound, 1'b1, byte_count_reg < COUNT_W'(MAX_FRAME_BYTES),
        "byte count past buffer")
    `RCLFR_ASSERT_NOW(a_failsafe_word, out_valid && kind == KIND_FAILSAFE,
        value[0] == failsafe_active, "failsafe word disagrees with flag")
    `RCLFR_ASSERT_NEXT(a_trig_starts_crc, accept && opcode == OP_BYTE && trig,
        state_reg == S_CRC && byte_count_reg == '0, "frame end did not start check")

endmodule
`default_nettype wire

/* sim/tb_rc_link_frame_receiver.sv */
// Self-checking testbench for rc_link_frame_receiver: frames, ticks, register sweeps.
// Depends on rclfr_pkg and the rc_link_frame_receiver RTL.
`timescale 1ns / 1ps

import rclfr_pkg::*;

typedef struct {
    kind_t       kind;
    logic [3:0]  idx;
    logic [15:0] val;
    logic        fs;
    logic        last;
} frame_result_t;

class frame_scoreboard;
    logic [7:0]  buf_mem [MAX_FRAME_BYTES];
    int unsigned cnt;
    int unsigned idle_ticks;
    int unsigned since_rc;
    bit          fs_flag;
    logic [15:0] sync_errs;
    logic [15:0] crc_errs;
    logic [15:0] drops;
    logic [7:0]  sync_val;
    logic [7:0]  poly;
    logic [15:0] byte_tmo;
    logic [15:0] fs_ticks;
    logic [10:0] raw_min;
    logic [16:0] ratio;
    logic [11:0] out_min;
    logic [11:0] out_max;
    frame_result_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
        cnt = 0; idle_ticks = 0; since_rc = 16'hFFFF; fs_flag = 1;
        sync_errs = 0; crc_errs = 0; drops = 0;
        sync_val = 200; poly = 213; byte_tmo = 5; fs_ticks = 1000;
        raw_min = 172; ratio = 40950; out_min = 988; out_max = 2012;
        errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            CFG_SYNC_VALUE:   sync_val = d[7:0];
            CFG_CRC_POLY:     poly = d[7:0];
            CFG_BYTE_TIMEOUT: byte_tmo = d[15:0];
            CFG_FAILSAFE:     fs_ticks = d[15:0];
            CFG_RAW_MIN:      raw_min = d[10:0];
            CFG_SCALE_RATIO:  ratio = d[16:0];
            CFG_OUT_MIN:      out_min = d[11:0];
            CFG_OUT_MAX:      out_max = d[11:0];
            default: ;
        endcase
    endfunction

    function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
        crc = crc ^ b;
        for (int k = 0; k < 8; k++)
            crc = crc[7] ? ((crc << 1) ^ poly) : (crc << 1);
        return crc;
    endfunction

    function int unsigned rd(int unsigned i);
        if (i >= cnt || i >= MAX_FRAME_BYTES)
            return 0;
        return buf_mem[i];
    endfunction

    function void push(kind_t k, int unsigned idx, int unsigned v);
        frame_result_t r;
        r.kind = k; r.idx = idx[3:0]; r.val = v[15:0]; r.fs = fs_flag; r.last = 0;
        pending.push_back(r);
    endfunction

    function logic [15:0] scale(int unsigned raw);
        longint d, t, q;
        d = longint'(raw) - longint'(raw_min);
        t = longint'(out_min) * 65536 + longint'(ratio) * d + 32768;
        q = t >>> 16;
        if (q < longint'(out_min)) q = out_min;
        if (q > longint'(out_max)) q = out_max;
        return q[15:0];
    endfunction

    function void run_frame();
        int unsigned len, w, p, base;
        logic [7:0] crc;
        bit sync_ok, crc_ok;
        len = rd(1);
        sync_ok = rd(0) == sync_val;
        if (!sync_ok) begin
            sync_errs++;
            push(KIND_SYNC_ERR, 0, sync_errs);
        end
        crc = 0;
        for (int unsigned i = 0; i < len - 1; i++)
            crc = crc_step(crc, rd(2 + i));
        crc_ok = crc == rd(len + 1);
        if (!crc_ok) begin
            crc_errs++;
            push(KIND_CRC_ERR, 0, crc_errs);
        end
        if (!sync_ok || !crc_ok)
            return;
        if (rd(2) == RC_FRAME_TYPE) begin
            for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
                p = 11 * i;
                base = 3 + (p >> 3);
                w = rd(base) | (rd(base + 1) << 8) | (rd(base + 2) << 16);
                push(KIND_CHANNEL, i, scale((w >> (p & 7)) & RAW_MASK));
            end
            since_rc = 0;
        end
        else if (rd(2) == LINK_FRAME_TYPE) begin
            for (int unsigned i = 0; i < LINK_STAT_BYTES; i++)
                push(KIND_LINK_STAT, i, rd(3 + i));
        end
    endfunction

    function void note_input(logic op, logic [7:0] b);
        int n0;
        bit nf;
        n0 = pending.size();
        if (op == OP_BYTE) begin
            if (cnt < MAX_FRAME_BYTES - 1) begin
                buf_mem[cnt] = b;
                cnt++;
            end
            idle_ticks = 0;
            if (cnt > MIN_FRAME_BYTES && cnt == rd(1) + 2) begin
                run_frame();
                cnt = 0;
            end
        end
        else begin
            if (idle_ticks < 16'hFFFF) idle_ticks++;
            if (since_rc < 16'hFFFF) since_rc++;
            if (idle_ticks > byte_tmo && cnt > 0) begin
                drops++;
                cnt = 0;
                push(KIND_TIMEOUT, 0, drops);
            end
            nf = since_rc > fs_ticks;
            if (nf != fs_flag) begin
                fs_flag = nf;
                push(KIND_FAILSAFE, 0, nf);
            end
        end
        if (pending.size() > n0)
            pending[$].last = 1;
    endfunction

    function void check_result(logic [2:0] k, logic [3:0] idx, logic [15:0] v,
                               logic fs, logic last);
        frame_result_t e;
        if (pending.size() == 0) begin
            $error("unexpected word: kind %0d index %0d value %0d", k, idx, v);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (k !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, k); errors++;
        end
        if (idx !== e.idx) begin
            $error("item_index: expected %0d actual %0d", e.idx, idx); errors++;
        end
        if (v !== e.val) begin
            $error("value: expected %0d actual %0d", e.val, v); errors++;
        end
        if (fs !== e.fs) begin
            $error("failsafe_active: expected %0d actual %0d", e.fs, fs); errors++;
        end
        if (last !== e.last) begin
            $error("last_of_run: expected %0d actual %0d", e.last, last); errors++;
        end
    endfunction
endclass

module tb_rc_link_frame_receiver;
    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 6000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        opcode = OP_BYTE;
    logic [7:0]  rx_byte = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  kind;
    logic [3:0]  item_index;
    logic [15:0] value;
    logic        failsafe_active;
    logic        last_of_run;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    frame_scoreboard sb = new();
    int unsigned words_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned idle_cycles = 0;
    bit          allow_idle = 1;

    rc_link_frame_receiver u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .item_index(item_index), .value(value),
        .failsafe_active(failsafe_active), .last_of_run(last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(kind, item_index, value, failsafe_active, last_of_run);
    end

    // watchdog: cycles with no accepted word on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
            $display("rc_link_frame_receiver: mismatch");
            $finish;
        end
    end

    // receiver back-pressure in bursts
    initial
    begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            out_stall <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            if (allow_idle && $urandom_range(0, 2) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    task automatic send_word(logic op, logic [7:0] b);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1;
        opcode   <= op;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, b);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(OP_TICK, $urandom_range(0, 255));
    endtask

    // sync, len, type, payload, crc; crc over type+payload
    task automatic send_frame(logic [7:0] sync, logic [7:0] ftype, int n_payload,
                              bit bad_crc, bit rand_payload, logic [7:0] fill);
        logic [7:0] body[$];
        logic [7:0] crc;
        body.push_back(ftype);
        for (int i = 0; i < n_payload; i++)
            body.push_back(rand_payload ? 8'($urandom_range(0, 255)) : fill);
        crc = 0;
        foreach (body[i]) crc = sb.crc_step(crc, body[i]);
        if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
        send_word(OP_BYTE, sync);
        send_word(OP_BYTE, 8'(n_payload + 2));
        foreach (body[i]) send_word(OP_BYTE, body[i]);
        send_word(OP_BYTE, crc);
        frames_sent++;
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
        in_valid  <= 0;
        wait (sb.pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_reg(idx, d);
    endtask

    task automatic write_all(logic [7:0] s, logic [7:0] p, logic [15:0] bt, logic [15:0] ft,
                             logic [10:0] rm, logic [16:0] ra, logic [11:0] mn,
                             logic [11:0] mx);
        write_cfg(CFG_SYNC_VALUE, s);
        write_cfg(CFG_CRC_POLY, p);
        write_cfg(CFG_BYTE_TIMEOUT, bt);
        write_cfg(CFG_FAILSAFE, ft);
        write_cfg(CFG_RAW_MIN, rm);
        write_cfg(CFG_SCALE_RATIO, ra);
        write_cfg(CFG_OUT_MIN, mn);
        write_cfg(CFG_OUT_MAX, mx);
    endtask

    task automatic random_item();
        int sel;
        logic [7:0] s;
        sel = $urandom_range(0, 99);
        s = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : sb.sync_val;
        if (sel < 35)
            send_frame(s, RC_FRAME_TYPE, 22, $urandom_range(0, 7) == 0, 1, 0);
        else if (sel < 50)
            send_frame(s, LINK_FRAME_TYPE, $urandom_range(1, 12),
                       $urandom_range(0, 7) == 0, 1, 0);
        else if (sel < 58)
            send_frame(s, $urandom_range(0, 255), $urandom_range(1, 8),
                       $urandom_range(0, 3) == 0, 1, 0);
        else if (sel < 85)
            send_tick();
        else
            send_word(OP_BYTE, $urandom_range(0, 255));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, reset settings
        send_frame(sb.sync_val, RC_FRAME_TYPE, 22, 0, 0, 8'h00);
        send_tick();                                    // failsafe clears
        send_frame(sb.sync_val, RC_FRAME_TYPE, 22, 0, 0, 8'hFF);
        send_frame(sb.sync_val, LINK_FRAME_TYPE, 10, 0, 1, 0);
        send_frame(sb.sync_val, 8'h33, 2, 0, 1, 0);     // other type: silent
        send_frame(sb.sync_val ^ 8'h01, LINK_FRAME_TYPE, 10, 0, 1, 0);
        send_frame(sb.sync_val, RC_FRAME_TYPE, 22, 1, 1, 0);
        send_frame(8'h00, RC_FRAME_TYPE, 22, 1, 1, 0);  // both errors
        send_word(OP_BYTE, sb.sync_val);                // partial frame, then idle drop
        send_word(OP_BYTE, 8'd30);
        repeat (7) send_tick();
        send_word(OP_BYTE, sb.sync_val);                // overfull buffer
        send_word(OP_BYTE, 8'd255);
        repeat (66) send_word(OP_BYTE, $urandom_range(0, 255));
        repeat (7) send_tick();

        // low extremes
        write_all(8'h00, 8'h00, 16'h0000, 16'h0000, 11'h000, 17'h00000, 12'h000, 12'hFFF);
        repeat (4) random_item();
        // high extremes, min above max
        write_all(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 11'h7FF, 17'h1FFFF, 12'hFFF, 12'h000);
        repeat (4) random_item();
        repeat (4) begin
            write_all($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 12), $urandom_range(0, 30),
                      $urandom_range(0, 2047), $urandom_range(0, 131071),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
            repeat (2) random_item();
        end
        write_all(8'hC8, 8'hD5, 16'd3, 16'd5, 11'd172, 17'd40950, 12'd988, 12'd2012);
        while (words_sent < 440) random_item();
        allow_idle = 0;
        repeat (3) random_item();

        in_valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d words, %0d frames, %0d results checked across register sweeps",
                 words_sent, frames_sent, sb.checked);
        $display("sync errs %0d, crc errs %0d, idle drops %0d",
                 sb.sync_errs, sb.crc_errs, sb.drops);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("rc_link_frame_receiver: match");
        else
            $display("rc_link_frame_receiver: mismatch");
        $finish;
    end
endmodule
